FILE: rtl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    localparam int PAGE_W = 12;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 13;

    // Configuration register map, indexed by word address.
    localparam logic [0:0]       REG_PAGE_COUNT   = 1'b0;
    localparam logic [CFG_W-1:0] PAGE_COUNT_RESET = 13'd4096;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

    // Response status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] page_no;
    } t_req;

    typedef struct packed {
        logic [PAGE_W-1:0] result_page;
        logic [STAT_W-1:0] status;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic init_wr;
        logic load_start;
        logic rd_en;
        logic check;
        logic next_word;
        logic wrap;
        logic write;
        logic resp_load;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic imm;
        logic is_alloc;
        logic hit;
        logic more;
        logic can_wrap;
        logic init_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/bpa_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-stage division by a constant: a multiply by a rounded-up reciprocal,
// exact for every input of XW bits, then the word base is rebuilt.
module bpa_div #(
    parameter int XW      = 13,
    parameter int DIVISOR = 32,
    parameter int QW      = 7
) (
    input  logic          i_clk,
    input  logic [XW-1:0] i_x,
    output logic [QW-1:0] o_q,
    output logic [XW-1:0] o_base
);

    localparam int LOGD = $clog2(DIVISOR);
    localparam int SH   = XW + LOGD;
    localparam int MW   = XW + 1;
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];

    logic [XW+MW-1:0]    r_prod;
    logic [XW+MW-1-SH:0] quot;
    logic [QW-1:0]       r_q;
    logic [XW-1:0]       r_base;

    assign quot = r_prod[XW+MW-1:SH];

    always_ff @(posedge i_clk) begin
        r_prod <= (XW+MW)'(i_x) * (XW+MW)'(RECIP_M);
        r_q    <= quot[QW-1:0];
        r_base <= XW'(quot) * XW'(DIVISOR);
    end

    assign o_q    = r_q;
    assign o_base = r_base;

endmodule

`default_nettype wire

FILE: rtl/bpa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bpa_datapath #(
    parameter int MAX_PAGES = 4096,
    parameter int WORD_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bpa_pkg::t_req            i_req,
    input  logic [bpa_pkg::CFG_W-1:0] i_page_count,
    input  bpa_pkg::t_ctl            i_ctl,
    input  logic                     i_rsp_ready,
    output bpa_pkg::t_sts            o_sts,
    output logic                     o_rsp_valid,
    output bpa_pkg::t_rsp            o_rsp
);

    import bpa_pkg::*;

    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int PGW       = $clog2(MAX_PAGES);
    localparam int SUMW      = $clog2(MAX_PAGES + WORD_BITS);
    localparam int AW        = (SUMW > CFG_W) ? SUMW : CFG_W;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    logic [CMD_W-1:0]     r_cmd;
    logic [AW-1:0]        r_x;
    logic [PGW-1:0]       r_search;
    logic [WAW-1:0]       r_word;
    logic [AW-1:0]        r_base;
    logic                 r_phase_b;
    logic [BW-1:0]        r_bit;
    logic [WORD_BITS-1:0] r_rdata;
    logic [WAW-1:0]       r_init_cnt;
    t_rsp                 r_res;
    logic                 r_out_vld;
    t_rsp                 r_out;

    logic [AW-1:0]        cnt_ext, count, idx_ext, search_ext, start;
    logic                 req_alloc, req_frees, req_imm;
    logic [WAW-1:0]       div_q;
    logic [AW-1:0]        div_base;
    logic [AW-1:0]        lo, hi, lo_d, hi_d, next_base, page_sum;
    logic [WORD_BITS-1:0] lo_mask, hi_mask, free_bits, bit_mask;
    logic [BW-1:0]        enc_bit;
    logic                 mem_we;
    logic [WAW-1:0]       mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // Effective page count and the start of the next-fit search.
    assign cnt_ext    = AW'(i_page_count);
    assign count      = (cnt_ext > AW'(MAX_PAGES)) ? AW'(MAX_PAGES) : cnt_ext;
    assign idx_ext    = AW'(i_req.page_no);
    assign search_ext = AW'(r_search);
    assign start      = (search_ext < count) ? search_ext : '0;

    assign req_alloc = (i_req.cmd == CMD_ALLOC);
    assign req_frees = (i_req.cmd == CMD_FREE) || (i_req.cmd == CMD_RESERVE);
    assign req_imm   = (req_alloc && (count == '0)) ||
                       (req_frees && (idx_ext >= count)) ||
                       (!req_alloc && !req_frees);

    bpa_div #(
        .XW      (AW),
        .DIVISOR (WORD_BITS),
        .QW      (WAW)
    ) u_div (
        .i_clk  (i_clk),
        .i_x    (r_x),
        .o_q    (div_q),
        .o_base (div_base)
    );

    // Window of the current word that lies inside [lo, hi).
    assign lo        = r_phase_b ? '0 : r_x;
    assign hi        = r_phase_b ? r_x : count;
    assign lo_d      = lo - r_base;
    assign hi_d      = hi - r_base;
    assign next_base = r_base + AW'(WORD_BITS);
    assign page_sum  = r_base + AW'(r_bit);

    always_comb begin
        if (lo <= r_base) begin
            lo_mask = {WORD_BITS{1'b1}};
        end else begin
            lo_mask = {WORD_BITS{1'b1}} << lo_d[BW-1:0];
        end
        if (hi >= next_base) begin
            hi_mask = {WORD_BITS{1'b1}};
        end else if (hi <= r_base) begin
            hi_mask = '0;
        end else begin
            hi_mask = ~({WORD_BITS{1'b1}} << hi_d[BW-1:0]);
        end
    end

    assign free_bits = ~r_rdata & lo_mask & hi_mask;

    // Lowest free bit wins.
    always_comb begin
        enc_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                enc_bit = BW'(i);
            end
        end
    end

    assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit;
    assign mem_we    = i_ctl.init_wr || i_ctl.write;
    assign mem_waddr = i_ctl.init_wr ? r_init_cnt : r_word;
    assign mem_wdata = i_ctl.init_wr ? {WORD_BITS{1'b1}} :
                       (r_cmd == CMD_FREE) ? (r_rdata & ~bit_mask) : (r_rdata | bit_mask);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= mem[r_word];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cnt <= '0;
            r_search   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_ctl.init_wr) begin
                r_init_cnt <= r_init_cnt + WAW'(1);
            end
            if (i_ctl.write) begin
                r_search <= page_sum[PGW-1:0];
            end
            if (i_ctl.resp_load) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd             <= i_req.cmd;
            r_x               <= req_alloc ? start : idx_ext;
            r_res.result_page <= req_alloc ? '0 : i_req.page_no;
            r_res.status      <= req_alloc ? STAT_NO_FREE :
                                 req_frees ? STAT_RANGE : STAT_OK;
        end
        if (i_ctl.load_start) begin
            r_word    <= div_q;
            r_base    <= div_base;
            r_phase_b <= 1'b0;
        end else if (i_ctl.next_word) begin
            r_word <= r_word + WAW'(1);
            r_base <= next_base;
        end else if (i_ctl.wrap) begin
            r_word    <= '0;
            r_base    <= '0;
            r_phase_b <= 1'b1;
        end
        if (i_ctl.check) begin
            r_bit <= (r_cmd == CMD_ALLOC) ? enc_bit : lo_d[BW-1:0];
        end
        if (i_ctl.write) begin
            r_res.result_page <= page_sum[PAGE_W-1:0];
            r_res.status      <= STAT_OK;
        end
        if (i_ctl.resp_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts.imm       = req_imm;
    assign o_sts.is_alloc  = (r_cmd == CMD_ALLOC);
    assign o_sts.hit       = |free_bits;
    assign o_sts.more      = (next_base < hi);
    assign o_sts.can_wrap  = !r_phase_b && (r_x != '0);
    assign o_sts.init_last = (r_init_cnt == WAW'(MAP_WORDS - 1));
    assign o_sts.out_free  = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire

FILE: rtl/bpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  bpa_pkg::t_sts i_sts,
    output logic          o_req_ready,
    output bpa_pkg::t_ctl o_ctl
);

    import bpa_pkg::*;

    typedef enum logic [8:0] {
        ST_INIT  = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_DIV1  = 9'b000000100,
        ST_DIV2  = 9'b000001000,
        ST_SETUP = 9'b000010000,
        ST_RD    = 9'b000100000,
        ST_CHK   = 9'b001000000,
        ST_WR    = 9'b010000000,
        ST_RESP  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_ctl.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = i_sts.imm ? ST_RESP : ST_DIV1;
                end
            end
            ST_DIV1: n_state = ST_DIV2;
            ST_DIV2: n_state = ST_SETUP;
            ST_SETUP: begin
                o_ctl.load_start = 1'b1;
                n_state          = ST_RD;
            end
            ST_RD: begin
                o_ctl.rd_en = 1'b1;
                n_state     = ST_CHK;
            end
            ST_CHK: begin
                if (!i_sts.is_alloc || i_sts.hit) begin
                    o_ctl.check = 1'b1;
                    n_state     = ST_WR;
                end else if (i_sts.more) begin
                    o_ctl.next_word = 1'b1;
                    n_state         = ST_RD;
                end else if (i_sts.can_wrap) begin
                    o_ctl.wrap = 1'b1;
                    n_state    = ST_RD;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_WR: begin
                o_ctl.write = 1'b1;
                n_state     = ST_RESP;
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_ctl.resp_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    assign o_req_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Page frame allocator with one used bit per page, held in a single-port word
// memory, and a next-fit search index. After reset the block first runs a
// clearing pass that marks every page used, one map word per cycle, and it
// takes no request until that pass is done; software then frees the pages
// that really exist. An allocate request scans the map word by word from the
// search index up to the page count, then wraps round to page 0, and returns
// the lowest free page it meets. A request that can be answered at once
// (unknown command, index out of range, page count of zero) goes straight
// from acceptance to the response state. Free and reserve pass through the
// divider states DIV1 and DIV2, which split the index into word and bit, then
// SETUP, then a read, a check and a write of the map word. An allocate request
// repeats the read and the check for each map word until a free page turns
// up; a full miss with wrap-around reads up to MAP_WORDS + 1 words. One
// request is in the block at a time, but a finished response waits in the
// output register while the next request is accepted.
module bitmap_page_allocator #(
    parameter int MAX_PAGES = 4096,
    parameter int WORD_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,

    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bpa_pkg::t_req i_req,

    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output bpa_pkg::t_rsp o_rsp,

    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    import bpa_pkg::*;

    logic [CFG_W-1:0] r_page_count;
    logic             cfg_wr;
    t_ctl             ctl;
    t_sts             sts;

    // The register port is a simple APB slave with no wait states. The
    // register is picked by word address; byte offset bits are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PAGE_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= PAGE_COUNT_RESET;
        end else if (cfg_wr) begin
            r_page_count <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_PAGE_COUNT) ? 32'(r_page_count) : '0;

    // The controller sequences each request; the datapath holds the map, the
    // search index, the scan window and the output register.
    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_sts       (sts),
        .o_req_ready (o_req_ready),
        .o_ctl       (ctl)
    );

    bpa_datapath #(
        .MAX_PAGES (MAX_PAGES),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_page_count (r_page_count),
        .i_ctl        (ctl),
        .i_rsp_ready  (i_rsp_ready),
        .o_sts        (sts),
        .o_rsp_valid  (o_rsp_valid),
        .o_rsp        (o_rsp)
    );

endmodule

`default_nettype wire

FILE: tb/tb_bitmap_page_allocator.sv
`timescale 1ns / 1ps

// Self-checking bench for the bitmap page allocator.
//
// A clocked driver takes requests from a backlog that the stimulus process
// fills, and at the moment the block accepts a request it runs the request
// through a behavioural copy of the allocator. The copy holds its own used
// map, search pointer and page count. The expected response goes on a queue.
// A clocked monitor compares every response with the oldest entry of that
// queue, field by field.
// Both sides draw a random pause for every request. Some phases run with no
// pauses at all. Two phases make the receiver hold off for a long stretch so
// that the block fills up, and two stop the sender until every response
// has come back.
module tb_bitmap_page_allocator;

    import bpa_pkg::*;

    localparam int          FRAMES         = 4096;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          LONG_HOLD      = 300;
    localparam int          WATCHDOG_LIMIT = 5000;
    // The package names no code for the spare command value.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;

    logic        req_valid = 1'b0;
    logic        req_ready;
    t_req        req_bus   = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    t_rsp        rsp_bus;

    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // Behavioural copy of the allocator state.
    bit          page_used [FRAMES];
    logic [11:0] search_ptr;
    logic [12:0] cfg_pages;

    // Request backlog for the driver and responses still owed by the block.
    t_req        cmd_backlog [$];
    t_rsp        pending_rsp [$];

    // Stimulus-side controls read by the driver and the monitor.
    bit          no_idle     = 1'b0;
    int unsigned holds_asked = 0;
    int unsigned holds_done  = 0;

    int unsigned req_gap     = 0;
    int unsigned rsp_wait    = 0;
    int unsigned idle_cycles = 0;

    int unsigned failures    = 0;
    int unsigned requests_sent = 0;
    int unsigned grants      = 0;
    int unsigned refusals    = 0;
    int unsigned out_of_range = 0;
    int unsigned settings_run = 0;

    bitmap_page_allocator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_bus),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_bus),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    // The page count saturates at the size of the map.
    function automatic int unsigned effective_pages();
        return (cfg_pages > FRAMES) ? FRAMES : int'(cfg_pages);
    endfunction

    // Works out the response to one request and updates the copied state the
    // way the block should.
    function automatic t_rsp allocator_response(t_req req);
        t_rsp        rsp;
        int unsigned lim;
        int unsigned pg;
        int unsigned n;
        bit          found;
        lim             = effective_pages();
        rsp.result_page = req.page_no;
        rsp.status      = STAT_OK;
        case (req.cmd)
            CMD_ALLOC: begin
                rsp.result_page = '0;
                rsp.status      = STAT_NO_FREE;
                // A search pointer beyond the page count restarts at page 0.
                pg    = (search_ptr < lim) ? int'(search_ptr) : 0;
                found = 1'b0;
                for (n = 0; n < lim && !found; n++) begin
                    if (!page_used[pg]) begin
                        page_used[pg]   = 1'b1;
                        search_ptr      = pg[11:0];
                        rsp.result_page = pg[11:0];
                        rsp.status      = STAT_OK;
                        found           = 1'b1;
                    end else begin
                        pg = (pg + 1 >= lim) ? 0 : pg + 1;
                    end
                end
                if (found) begin
                    grants++;
                end else begin
                    refusals++;
                end
            end
            CMD_FREE, CMD_RESERVE: begin
                if (req.page_no >= lim) begin
                    rsp.status = STAT_RANGE;
                    out_of_range++;
                end else begin
                    page_used[req.page_no] = (req.cmd == CMD_RESERVE);
                    search_ptr             = req.page_no;
                end
            end
            default: begin
                // The spare command leaves everything alone and echoes the index.
            end
        endcase
        return rsp;
    endfunction

    // Request driver. The expected response is worked out at the edge that
    // accepts the request, so it always sees the configuration in force then.
    always @(posedge clk) begin : request_driver
        int unsigned gap;
        if (!rst_n) begin
            req_valid <= 1'b0;
            req_gap   <= 0;
        end else if (req_valid && req_ready) begin
            pending_rsp.push_back(allocator_response(req_bus));
            requests_sent++;
            gap = no_idle ? 0 : $urandom_range(0, 12);
            if (gap == 0 && cmd_backlog.size() > 0) begin
                // Back-to-back: valid stays high and only the payload moves on.
                req_bus <= cmd_backlog.pop_front();
            end else begin
                req_valid <= 1'b0;
                req_gap   <= gap;
            end
        end else if (!req_valid) begin
            if (req_gap > 0) begin
                req_gap <= req_gap - 1;
            end else if (cmd_backlog.size() > 0) begin
                req_bus   <= cmd_backlog.pop_front();
                req_valid <= 1'b1;
            end
        end
    end

    // Response monitor. It also owns the ready line, including the long
    // hold-off, which it counts down itself once the stimulus asks for one.
    always @(posedge clk) begin : response_monitor
        t_rsp        want;
        int unsigned pause;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            rsp_wait  <= 0;
        end else if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("response with no request outstanding: result_page %0d status %0d",
                       rsp_bus.result_page, rsp_bus.status);
                failures++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_bus.result_page !== want.result_page) begin
                    $error("result_page: expected %0d, actual %0d",
                           want.result_page, rsp_bus.result_page);
                    failures++;
                end
                if (rsp_bus.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                    failures++;
                end
            end
            pause = no_idle ? 0 : $urandom_range(0, 12);
            if (holds_asked != holds_done) begin
                holds_done = holds_asked;
                rsp_ready <= 1'b0;
                rsp_wait  <= LONG_HOLD;
            end else if (pause != 0) begin
                rsp_ready <= 1'b0;
                rsp_wait  <= pause;
            end
        end else if (!rsp_ready) begin
            if (rsp_wait > 0) begin
                rsp_wait <= rsp_wait - 1;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any stretch without a single handshake on either channel
    // that is far longer than the slowest legal allocate ends the run.
    always @(posedge clk) begin : watchdog
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bitmap_page_allocator verification failed");
            $finish;
        end
    end

    task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] idx);
        t_req r;
        r.cmd     = cmd;
        r.page_no = idx;
        cmd_backlog.push_back(r);
    endtask

    // Waits until every queued request has gone in and been answered, then
    // gives the block a few more cycles to settle before anything is changed.
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || req_valid || pending_rsp.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the page count through the register port with random upper bits,
    // which the block must drop, and reads it back.
    task automatic set_page_count(input int unsigned value);
        logic [31:0] word;
        logic [31:0] got;
        word = {$urandom() & 32'hFFFF_E000} | (value & 32'h1FFF);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_PAGE_COUNT, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cfg_pages = word[12:0];
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {19'd0, cfg_pages}) begin
            $error("page_count readback: expected %0d, actual %0d", cfg_pages, got);
            failures++;
        end
        settings_run++;
    endtask

    // One random phase under a given page count. Most requests are well
    // formed for that count; about one in seven carry a full-range index and a
    // few use the spare command. An optional run of frees from page 0 up
    // plays the part of software handing over the pages that exist.
    task automatic run_phase(input int unsigned count_val, input int unsigned n_items,
                             input int unsigned prefree, input bit burst,
                             input bit long_hold, input bit mid_pause);
        int unsigned lim;
        int unsigned sel;
        int unsigned k;
        t_req        r;
        wait_idle();
        set_page_count(count_val);
        lim     = effective_pages();
        no_idle = burst;
        if (long_hold) begin
            holds_asked++;
        end
        for (k = 0; k < prefree && k < lim; k++) begin
            queue_request(CMD_FREE, k[11:0]);
        end
        for (k = 0; k < n_items; k++) begin
            if (mid_pause && k == n_items / 2) begin
                // The sender stops here until the block has answered everything.
                wait_idle();
            end
            sel = $urandom_range(0, 99);
            if (lim > 0 && sel < 85) begin
                r.page_no = 12'($urandom_range(0, lim - 1));
            end else begin
                r.page_no = 12'($urandom());
            end
            if (sel < 38) begin
                r.cmd = CMD_ALLOC;
            end else if (sel < 70) begin
                r.cmd = CMD_FREE;
            end else if (sel < 85) begin
                r.cmd = CMD_RESERVE;
            end else if (sel < 95) begin
                r.cmd = sel[0] ? CMD_FREE : CMD_RESERVE;
            end else begin
                r.cmd = CMD_UNUSED;
            end
            cmd_backlog.push_back(r);
        end
    endtask

    initial begin : stimulus
        int unsigned i;
        for (i = 0; i < FRAMES; i++) begin
            page_used[i] = 1'b1;
        end
        search_ptr = '0;
        cfg_pages  = PAGE_COUNT_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset page count. Every page starts used, so
        // the first allocate must be refused.
        queue_request(CMD_ALLOC, 12'd0);
        queue_request(CMD_FREE, 12'd0);
        queue_request(CMD_FREE, 12'd4095);
        queue_request(CMD_FREE, 12'd31);
        queue_request(CMD_FREE, 12'd32);
        // Next fit from page 32, then up to the top page, then round to 0.
        queue_request(CMD_ALLOC, 12'd0);
        queue_request(CMD_ALLOC, 12'd0);
        queue_request(CMD_ALLOC, 12'd0);
        queue_request(CMD_ALLOC, 12'd0);
        queue_request(CMD_ALLOC, 12'd0);
        queue_request(CMD_UNUSED, 12'hFFF);
        queue_request(CMD_RESERVE, 12'd100);
        wait_idle();

        // A page count of zero makes every page invalid.
        set_page_count(0);
        queue_request(CMD_ALLOC, 12'd0);
        queue_request(CMD_FREE, 12'd5);
        wait_idle();

        // Largest register value saturates to the size of the map. The search
        // pointer is left at the top page on purpose.
        set_page_count(13'h1FFF);
        queue_request(CMD_FREE, 12'd5);
        queue_request(CMD_FREE, 12'd4095);
        queue_request(CMD_ALLOC, 12'd0);
        wait_idle();

        // Search pointer beyond the new count: the scan must start at page 0.
        set_page_count(16);
        queue_request(CMD_ALLOC, 12'd0);
        queue_request(CMD_FREE, 12'd16);
        queue_request(CMD_RESERVE, 12'd15);
        wait_idle();

        // Smallest non-zero count.
        set_page_count(1);
        queue_request(CMD_FREE, 12'd0);
        queue_request(CMD_ALLOC, 12'd0);
        queue_request(CMD_ALLOC, 12'd0);
        queue_request(CMD_RESERVE, 12'd4095);

        // Random phases: page count, requests, frees up front, no idling,
        // long receiver hold-off, sender pause half way.
        run_phase(4096, 175, 64, 1'b0, 1'b0, 1'b0);
        run_phase(33,   100, 33, 1'b1, 1'b0, 1'b0);
        run_phase(4095, 100, 40, 1'b0, 1'b1, 1'b0);
        run_phase(2,    120,  2, 1'b0, 1'b0, 1'b0);
        run_phase(8191, 100, 20, 1'b0, 1'b0, 1'b1);
        run_phase($urandom_range(1, 4096), 100, 48, 1'b0, 1'b0, 1'b0);
        run_phase(4097, 100,  0, 1'b1, 1'b0, 1'b0);
        run_phase(0,     30,  0, 1'b0, 1'b0, 1'b0);
        run_phase(1,     60,  1, 1'b0, 1'b0, 1'b0);
        run_phase($urandom_range(3, 64), 100, 64, 1'b0, 1'b1, 1'b1);

        wait_idle();
        repeat (50) @(posedge clk);

        $display("Ran %0d requests under %0d page-count settings, from zero to saturated.",
                 requests_sent, settings_run);
        $display("Allocations granted %0d, refused %0d; out-of-range frees and reserves %0d.",
                 grants, refusals, out_of_range);
        if (failures == 0) begin
            $display("bitmap_page_allocator verification clean");
        end else begin
            $display("bitmap_page_allocator verification failed");
        end
        $finish;
    end

endmodule
